// ===== rtl/mgc_pkg.sv =====
// shared types and codes for the mutex grant coordinator
package mgc_pkg;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_QFULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_TFULL = 2'd3;

	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;        // capture event, apply queue update
		logic scan_start;  // begin table scan for scan_id
		logic scan_grant;  // scan target is the grant id (else requester)
		logic scan_step;   // examine one table entry
		logic scan_commit; // register/insert and count
		logic finish;      // present result
	} mgc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
		logic grant;
	} mgc_stat_t;

endpackage

// ===== rtl/mgc_ctrl.sv =====
// controller state machine for the mutex grant coordinator
module mgc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output mgc_pkg::mgc_cmd_t cmd,
	input  mgc_pkg::mgc_stat_t stat
);
	import mgc_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RSCAN = 3'd1;
	localparam logic [2:0] S_RCOM  = 3'd2;
	localparam logic [2:0] S_GSCAN = 3'd3;
	localparam logic [2:0] S_GCOM  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					cmd.scan_start = 1'b1;
					state_d = S_RSCAN;
				end
			end
			S_RSCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) state_d = S_RCOM;
			end
			S_RCOM: begin
				// commit is still for the requester scan
				cmd.scan_commit = 1'b1;
				if (stat.grant) begin
					cmd.scan_start = 1'b1;
					state_d = S_GSCAN;
				end else state_d = S_DONE;
			end
			S_GSCAN: begin
				cmd.scan_step = 1'b1;
				cmd.scan_grant = 1'b1;
				if (stat.scan_last) state_d = S_GCOM;
			end
			S_GCOM: begin
				cmd.scan_commit = 1'b1;
				cmd.scan_grant = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ===== rtl/mgc_dp.sv =====
// datapath: waiter queue, id table with grant tallies, result registers
module mgc_dp #(
	parameter int QUEUE_DEPTH = 256,
	parameter int TABLE_ENTRIES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mgc_pkg::mgc_cmd_t  cmd,
	output mgc_pkg::mgc_stat_t stat,
	input  logic               op,
	input  logic [15:0]        requester_id,
	output logic               done,
	output logic               granted,
	output logic [15:0]        grant_id,
	output logic [31:0]        grant_count,
	output logic [8:0]         waiting,
	output logic [1:0]         status
);
	import mgc_pkg::*;

	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OW = $clog2(QUEUE_DEPTH + 1);
	localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	logic [15:0] qmem [QUEUE_DEPTH];
	logic [15:0] kmem [TABLE_ENTRIES];
	logic [31:0] tmem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] used_q;

	logic [QW-1:0] head_q, tail_q;
	logic [OW-1:0] occ_q;
	logic [15:0] rid_q, gid_q, qrd_q, kid_q, scan_id;
	logic [31:0] tal_q, cnt_q;
	logic grant_q, miss_q;
	logic [1:0] st_q;
	logic [CW-1:0] idx_q;
	logic [TW-1:0] hit_q, free_q;
	logic hit_v_q, free_v_q, rd_v_q;
	logic [TW-1:0] ridx_q;
	logic done_q;
	logic op_q;

	logic [QW-1:0] head_nx;
	logic [OW-1:0] occ_nx;
	logic [TW-1:0] sel;
	logic have;

	assign head_nx = (32'(head_q) + 1 >= QUEUE_DEPTH) ? '0 : head_q + 1'b1;
	assign occ_nx = occ_q - 1'b1;
	assign scan_id = cmd.scan_grant ? gid_q : rid_q;
	assign stat.scan_last = !rd_v_q && (32'(idx_q) >= TABLE_ENTRIES);
	assign stat.grant = grant_q;
	assign have = hit_v_q || free_v_q;
	assign sel = hit_v_q ? hit_q : free_q;

	// queue memory: write at tail, read the next head when the word is taken
	always_ff @(posedge clk) begin
		if (cmd.load && op == OP_REQUEST && 32'(occ_q) < QUEUE_DEPTH)
			qmem[tail_q] <= requester_id;
		if (cmd.load) qrd_q <= qmem[head_nx];
	end

	// table memories: one read per scan step, write at commit
	always_ff @(posedge clk) begin
		if (cmd.scan_step && 32'(idx_q) < TABLE_ENTRIES) begin
			kid_q <= kmem[idx_q[TW-1:0]];
			tal_q <= tmem[idx_q[TW-1:0]];
		end
		if (cmd.scan_commit && have) begin
			if (!hit_v_q) kmem[sel] <= scan_id;
			if (cmd.scan_grant)
				tmem[sel] <= (hit_v_q ? cnt_q : 32'd0) +
					((hit_v_q && cnt_q == 32'hFFFF_FFFF) ? 32'd0 : 32'd1);
			else if (!hit_v_q) tmem[sel] <= 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0; head_q <= '0; tail_q <= '0; occ_q <= '0;
			idx_q <= '0; rd_v_q <= 1'b0; hit_v_q <= 1'b0; free_v_q <= 1'b0;
			grant_q <= 1'b0; miss_q <= 1'b0; st_q <= ST_OK; done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.load) begin
				rid_q <= requester_id;
				grant_q <= 1'b0;
				miss_q <= 1'b0;
				st_q <= ST_OK;
				gid_q <= '0;
				if (op == OP_REQUEST) begin
					if (32'(occ_q) >= QUEUE_DEPTH) st_q <= ST_QFULL;
					else begin
						tail_q <= (32'(tail_q) + 1 >= QUEUE_DEPTH) ? '0 : tail_q + 1'b1;
						occ_q <= occ_q + 1'b1;
						if (occ_q == '0) begin
							grant_q <= 1'b1;
							gid_q <= requester_id;
						end
					end
				end else begin
					if (occ_q == '0) st_q <= ST_EMPTY;
					else begin
						head_q <= head_nx;
						occ_q <= occ_nx;
						grant_q <= (occ_nx != '0);
					end
				end
			end
			if (cmd.scan_start) begin
				idx_q <= '0; rd_v_q <= 1'b0; hit_v_q <= 1'b0; free_v_q <= 1'b0;
			end else if (cmd.scan_step) begin
				if (32'(idx_q) < TABLE_ENTRIES) begin
					idx_q <= idx_q + 1'b1;
					ridx_q <= idx_q[TW-1:0];
					rd_v_q <= 1'b1;
				end else rd_v_q <= 1'b0;
				if (rd_v_q) begin
					if (used_q[ridx_q]) begin
						if (kid_q == scan_id && !hit_v_q) begin
							hit_v_q <= 1'b1; hit_q <= ridx_q; cnt_q <= tal_q;
						end
					end else if (!free_v_q) begin
						free_v_q <= 1'b1; free_q <= ridx_q;
					end
				end
			end
			if (cmd.scan_commit) begin
				if (have) used_q[sel] <= 1'b1;
				else miss_q <= 1'b1;
				// release grant id is the new head read at load
				if (!cmd.scan_grant && grant_q && op_q == OP_RELEASE) gid_q <= qrd_q;
				if (cmd.scan_grant)
					cnt_q <= have ? ((hit_v_q ? cnt_q : 32'd0) +
						((hit_v_q && cnt_q == 32'hFFFF_FFFF) ? 32'd0 : 32'd1)) : 32'd0;
				else cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) if (cmd.load) op_q <= op;

	assign done = done_q;
	assign granted = grant_q;
	assign grant_id = gid_q;
	assign grant_count = cnt_q;
	assign waiting = 9'(occ_q);
	assign status = (st_q == ST_OK && miss_q) ? ST_TFULL : st_q;
endmodule

// ===== rtl/mutex_grant_coordinator.sv =====
// top level of the mutex grant coordinator
// each event runs one or two linear table scans, one entry per cycle through the
// table memory read port
// throughput: one event at a time, busy is high from acceptance until done
// reset: arst_n clears queue pointers, occupancy and table valid bits at once
// results show for one cycle with done; the receiver cannot stall
module mutex_grant_coordinator #(
	parameter int QUEUE_DEPTH = 256,
	parameter int TABLE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [15:0] requester_id,
	output logic        done,
	output logic        granted,
	output logic [15:0] grant_id,
	output logic [31:0] grant_count,
	output logic [8:0]  waiting,
	output logic [1:0]  status
);
	import mgc_pkg::*;

	mgc_cmd_t  cmd;
	mgc_stat_t stat;

	mgc_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .cmd, .stat);

	mgc_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
		.clk, .arst_n, .cmd, .stat, .op, .requester_id, .done, .granted,
		.grant_id, .grant_count, .waiting, .status
	);

`ifndef ASSERT_OFF
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without busy");
	a_nogrant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !granted) |-> (grant_count == 32'd0)) else $error("count without grant");
	a_qfull_nogrant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_QFULL || status == ST_EMPTY)) |-> !granted)
		else $error("grant on error");
`endif
endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for the mutex grant coordinator
`timescale 1ns / 1ps

module tb_top;
	import mgc_pkg::*;

	localparam int QDEPTH = 256;
	localparam int TDEPTH = 256;
	localparam int IDLE_LIMIT = 5000;

	typedef struct {
		logic        granted;
		logic [15:0] grant_id;
		logic [31:0] grant_count;
		logic [8:0]  waiting;
		logic [1:0]  status;
	} grant_word_t;

	typedef struct {
		logic        op;
		logic [15:0] id;
		bit          typed;
		grant_word_t word;
	} lock_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        op = OP_REQUEST;
	logic [15:0] requester_id = '0;
	logic        busy, done, granted;
	logic [15:0] grant_id;
	logic [31:0] grant_count;
	logic [8:0]  waiting;
	logic [1:0]  status;

	// predictor state
	logic [15:0] waiter_line[$];
	logic [15:0] id_table[TDEPTH];
	bit          id_valid[TDEPTH];
	logic [31:0] grants_of[TDEPTH];
	grant_word_t pending_words[$];

	int          mismatches = 0;
	int          idle_cycles = 0;
	logic [15:0] id_pool[16];

	mutex_grant_coordinator #(.QUEUE_DEPTH(QDEPTH), .TABLE_ENTRIES(TDEPTH)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.requester_id(requester_id), .done(done), .granted(granted), .grant_id(grant_id),
		.grant_count(grant_count), .waiting(waiting), .status(status)
	);

	always #5 clk = ~clk;

	// first matching entry, else first free one (claimed), else -1
	function automatic int find_or_add(logic [15:0] id);
		int free_at;
		free_at = -1;
		for (int i = 0; i < TDEPTH; i++) begin
			if (id_valid[i]) begin
				if (id_table[i] == id) return i;
			end else if (free_at < 0) begin
				free_at = i;
			end
		end
		if (free_at >= 0) begin
			id_valid[free_at] = 1'b1;
			id_table[free_at] = id;
			grants_of[free_at] = '0;
		end
		return free_at;
	endfunction

	function automatic grant_word_t predict_grant(logic ev_op, logic [15:0] id);
		grant_word_t w;
		bit miss;
		int g;
		w = '{1'b0, 16'd0, 32'd0, 9'd0, ST_OK};
		miss = find_or_add(id) < 0;
		if (ev_op == OP_REQUEST) begin
			if (waiter_line.size() >= QDEPTH) begin
				w.status = ST_QFULL;
			end else begin
				if (waiter_line.size() == 0) begin
					w.granted = 1'b1;
					w.grant_id = id;
				end
				waiter_line.push_back(id);
			end
		end else begin
			if (waiter_line.size() == 0) begin
				w.status = ST_EMPTY;
			end else begin
				void'(waiter_line.pop_front());
				if (waiter_line.size() > 0) begin
					w.granted = 1'b1;
					w.grant_id = waiter_line[0];
				end
			end
		end
		if (w.granted) begin
			g = find_or_add(w.grant_id);
			if (g < 0) begin
				miss = 1'b1;
			end else begin
				if (grants_of[g] != 32'hFFFF_FFFF) grants_of[g]++;
				w.grant_count = grants_of[g];
			end
		end
		if (w.status == ST_OK && miss) w.status = ST_TFULL;
		w.waiting = 9'(waiter_line.size());
		return w;
	endfunction

	// hold start high across back-to-back words, drop it only for a gap
	task automatic send_event(logic ev_op, logic [15:0] id, bit typed, grant_word_t typed_word);
		int gap;
		grant_word_t w;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= ev_op;
		requester_id <= id;
		@(posedge clk);
		while (busy) @(posedge clk);
		w = predict_grant(ev_op, id);
		pending_words.push_back(typed ? typed_word : w);
	endtask

	task automatic send_random(int count, int release_pct, bit fresh_ids);
		logic [15:0] id;
		logic ev_op;
		for (int n = 0; n < count; n++) begin
			id = fresh_ids ? 16'($urandom_range(0, 65535)) : id_pool[$urandom_range(0, 15)];
			ev_op = ($urandom_range(0, 99) < release_pct) ? OP_RELEASE : OP_REQUEST;
			send_event(ev_op, id, 1'b0, '{1'b0, 16'd0, 32'd0, 9'd0, ST_OK});
		end
	endtask

	task automatic drain_words();
		start <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		grant_word_t e;
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: granted=%0d id=%h count=%0d waiting=%0d status=%0d",
						granted, grant_id, grant_count, waiting, status);
			end else begin
				e = pending_words.pop_front();
				if (granted !== e.granted || grant_id !== e.grant_id || grant_count !== e.grant_count
						|| waiting !== e.waiting || status !== e.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word mismatch: exp %0d/%h/%0d/%0d/%0d got %0d/%h/%0d/%0d/%0d",
							e.granted, e.grant_id, e.grant_count, e.waiting, e.status,
							granted, grant_id, grant_count, waiting, status);
				end
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	lock_event_t directed[] = '{
		'{OP_RELEASE, 16'h0000, 1'b1, '{1'b0, 16'h0000, 32'd0, 9'd0, ST_EMPTY}},
		'{OP_REQUEST, 16'h0000, 1'b1, '{1'b1, 16'h0000, 32'd1, 9'd1, ST_OK}},
		'{OP_REQUEST, 16'hFFFF, 1'b1, '{1'b0, 16'h0000, 32'd0, 9'd2, ST_OK}},
		'{OP_REQUEST, 16'h1234, 1'b1, '{1'b0, 16'h0000, 32'd0, 9'd3, ST_OK}},
		'{OP_RELEASE, 16'h5555, 1'b1, '{1'b1, 16'hFFFF, 32'd1, 9'd2, ST_OK}},
		'{OP_RELEASE, 16'hAAAA, 1'b1, '{1'b1, 16'h1234, 32'd1, 9'd1, ST_OK}},
		'{OP_RELEASE, 16'h0000, 1'b1, '{1'b0, 16'h0000, 32'd0, 9'd0, ST_OK}},
		'{OP_RELEASE, 16'hFFFF, 1'b1, '{1'b0, 16'h0000, 32'd0, 9'd0, ST_EMPTY}},
		'{OP_REQUEST, 16'h0000, 1'b1, '{1'b1, 16'h0000, 32'd2, 9'd1, ST_OK}},
		'{OP_REQUEST, 16'h0000, 1'b0, '{1'b0, 16'h0000, 32'd0, 9'd0, ST_OK}},
		'{OP_REQUEST, 16'h8001, 1'b0, '{1'b0, 16'h0000, 32'd0, 9'd0, ST_OK}},
		'{OP_RELEASE, 16'h7FFE, 1'b0, '{1'b0, 16'h0000, 32'd0, 9'd0, ST_OK}},
		'{OP_RELEASE, 16'h0001, 1'b0, '{1'b0, 16'h0000, 32'd0, 9'd0, ST_OK}},
		'{OP_RELEASE, 16'hFFFE, 1'b0, '{1'b0, 16'h0000, 32'd0, 9'd0, ST_OK}},
		'{OP_REQUEST, 16'hFFFF, 1'b0, '{1'b0, 16'h0000, 32'd0, 9'd0, ST_OK}},
		'{OP_RELEASE, 16'hFFFF, 1'b0, '{1'b0, 16'h0000, 32'd0, 9'd0, ST_OK}}
	};

	initial begin
		for (int i = 0; i < TDEPTH; i++) begin
			id_valid[i] = 1'b0;
			grants_of[i] = '0;
		end
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hFFFF;
		for (int i = 2; i < 16; i++) id_pool[i] = 16'($urandom_range(0, 65535));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k])
			send_event(directed[k].op, directed[k].id, directed[k].typed, directed[k].word);
		drain_words();

		// lock traffic over a small set of ids
		send_random(700, 45, 1'b0);
		drain_words();
		// fill the waiter queue past full and the id table with fresh ids
		send_random(270, 0, 1'b1);
		send_random(360, 55, 1'b1);

		drain_words();
		repeat (600) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/mgc_pkg.sv
rtl/mgc_ctrl.sv
rtl/mgc_dp.sv
rtl/mutex_grant_coordinator.sv
test/tb_top.sv
